### rtl/rsi_pkg.sv
// Package with widths and pipeline word types for the ray-sphere intersection core.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

  // Field formats.
  localparam int COORD_W    = 32;
  localparam int COORD_FRAC = 16;
  localparam int DIR_FRAC   = 14;
  localparam int DIR_W      = DIR_FRAC + 2;
  localparam int RAD_W      = COORD_W - 1;

  // Internal widths. A difference of two coordinates has a magnitude below 2^COORD_W.
  localparam int DX_W    = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int PROD_W  = DX_W + DIR_W;
  localparam int TC_W    = PROD_W + 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LSQ_W   = SQ_W + 2;
  localparam int TCQ_W   = COORD_W + 2;
  localparam int TCSQ_W  = 2 * TCQ_W;
  localparam int D_W     = (TCSQ_W > LSQ_W) ? TCSQ_W : LSQ_W;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int ROOT_W  = RAD_W;
  localparam int DIST_W  = TCQ_W + 2;

  // Pipeline layout: seven front stages, one stage per root bit, one output stage.
  localparam int SQ_FIRST = 7;
  localparam int NSTAGE   = SQ_FIRST + ROOT_W + 1;

  // Word carried through the square-root stages.
  typedef struct packed {
    logic              miss;
    logic [TCQ_W-1:0]  tcq;
    logic [RSQ_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage
`default_nettype wire

### rtl/ray_sphere_intersection_core.sv
// Top level of the pipelined ray-sphere intersection core.
`timescale 1ns / 1ps
`default_nettype none
// Geometric ray-sphere test on Q16.16 coordinates and a Q2.14 unit direction. Every
// word passes seven arithmetic stages (difference, products, sums, rounding of tc,
// tc squared, perpendicular distance, radius check), one stage per bit of the 31-bit
// square root, and an output register. A new word is accepted in every cycle unless a
// stalled output holds the pipeline; a stalled output only holds back stages that are full, so
// empty stages keep filling. A miss returns hit 0 and distance 0; a hit returns the
// entry distance, saturated, which is negative when the origin lies inside the sphere.
module ray_sphere_intersection_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     centre_x_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     centre_y_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     centre_z_i,
  input  wire logic        [rsi_pkg::RAD_W-1:0]       sphere_radius_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     origin_x_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     origin_y_i,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]     origin_z_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]       dir_x_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]       dir_y_i,
  input  wire logic signed [rsi_pkg::DIR_W-1:0]       dir_z_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        hit_o,
  output logic signed [rsi_pkg::COORD_W-1:0]          distance_o
);

  localparam int NS = rsi_pkg::NSTAGE;

  // Stage valid bits and per-stage advance enables.
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];

  // Valid bits follow the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: offset from origin to centre.
  logic signed [rsi_pkg::DX_W-1:0]  dx_q [3];
  logic signed [rsi_pkg::DIR_W-1:0] dir_q [3];
  logic        [rsi_pkg::RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q[0]  <= rsi_pkg::DX_W'(centre_x_i) - rsi_pkg::DX_W'(origin_x_i);
      dx_q[1]  <= rsi_pkg::DX_W'(centre_y_i) - rsi_pkg::DX_W'(origin_y_i);
      dx_q[2]  <= rsi_pkg::DX_W'(centre_z_i) - rsi_pkg::DX_W'(origin_z_i);
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
      rad_q    <= sphere_radius_i;
    end
  end

  // Stage 1: projection terms, squared offsets and squared radius.
  logic signed [rsi_pkg::PROD_W-1:0] prod_q [3];
  logic        [rsi_pkg::SQ_W-1:0]   sq_q [3];
  logic        [rsi_pkg::RSQ_W-1:0]  rsq1_q;
  logic        [rsi_pkg::DX_W-1:0]   dx_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx_abs[i] = dx_q[i][rsi_pkg::DX_W-1] ? -dx_q[i] : dx_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= rsi_pkg::PROD_W'(dx_q[i]) * rsi_pkg::PROD_W'(dir_q[i]);
        sq_q[i]   <= rsi_pkg::SQ_W'(dx_abs[i][rsi_pkg::MAG_W-1:0])
                   * rsi_pkg::SQ_W'(dx_abs[i][rsi_pkg::MAG_W-1:0]);
      end
      rsq1_q <= rsi_pkg::RSQ_W'(rad_q) * rsi_pkg::RSQ_W'(rad_q);
    end
  end

  // Stage 2: tc and the squared length of the offset.
  logic signed [rsi_pkg::TC_W-1:0]  tc_q;
  logic        [rsi_pkg::LSQ_W-1:0] lsq2_q;
  logic        [rsi_pkg::RSQ_W-1:0] rsq2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      tc_q   <= rsi_pkg::TC_W'(prod_q[0]) + rsi_pkg::TC_W'(prod_q[1])
              + rsi_pkg::TC_W'(prod_q[2]);
      lsq2_q <= rsi_pkg::LSQ_W'(sq_q[0]) + rsi_pkg::LSQ_W'(sq_q[1])
              + rsi_pkg::LSQ_W'(sq_q[2]);
      rsq2_q <= rsq1_q;
    end
  end

  // Stage 3: a ray pointing away misses; tc is rounded half up to coordinate format.
  logic [rsi_pkg::TC_W-1:0]   tc_rnd;
  logic                       miss3_q;
  logic [rsi_pkg::TCQ_W-1:0]  tcq3_q;
  logic [rsi_pkg::LSQ_W-1:0]  lsq3_q;
  logic [rsi_pkg::RSQ_W-1:0]  rsq3_q;

  assign tc_rnd = tc_q + (rsi_pkg::TC_W'(1) << (rsi_pkg::DIR_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      miss3_q <= tc_q[rsi_pkg::TC_W-1];
      tcq3_q  <= tc_rnd[rsi_pkg::DIR_FRAC +: rsi_pkg::TCQ_W];
      lsq3_q  <= lsq2_q;
      rsq3_q  <= rsq2_q;
    end
  end

  // Stage 4: tc squared.
  logic                        miss4_q;
  logic [rsi_pkg::TCQ_W-1:0]   tcq4_q;
  logic [rsi_pkg::TCSQ_W-1:0]  tcsq4_q;
  logic [rsi_pkg::LSQ_W-1:0]   lsq4_q;
  logic [rsi_pkg::RSQ_W-1:0]   rsq4_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      miss4_q <= miss3_q;
      tcq4_q  <= tcq3_q;
      tcsq4_q <= rsi_pkg::TCSQ_W'(tcq3_q) * rsi_pkg::TCSQ_W'(tcq3_q);
      lsq4_q  <= lsq3_q;
      rsq4_q  <= rsq3_q;
    end
  end

  // Stage 5: squared perpendicular distance as an absolute difference.
  logic [rsi_pkg::D_W-1:0]    tcsq_ext;
  logic [rsi_pkg::D_W-1:0]    lsq_ext;
  logic                       miss5_q;
  logic [rsi_pkg::TCQ_W-1:0]  tcq5_q;
  logic [rsi_pkg::D_W-1:0]    d2_q;
  logic [rsi_pkg::RSQ_W-1:0]  rsq5_q;

  assign tcsq_ext = rsi_pkg::D_W'(tcsq4_q);
  assign lsq_ext  = rsi_pkg::D_W'(lsq4_q);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      miss5_q <= miss4_q;
      tcq5_q  <= tcq4_q;
      d2_q    <= (tcsq_ext < lsq_ext) ? (lsq_ext - tcsq_ext) : (tcsq_ext - lsq_ext);
      rsq5_q  <= rsq4_q;
    end
  end

  // Stage 6: radius check and the value whose root is taken.
  rsi_pkg::sq_t s6_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_q.miss <= miss5_q || (d2_q > rsi_pkg::D_W'(rsq5_q));
      s6_q.tcq  <= tcq5_q;
      s6_q.rem  <= rsq5_q - d2_q[rsi_pkg::RSQ_W-1:0];
      s6_q.root <= '0;
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  rsi_pkg::sq_t sq_stage_q [rsi_pkg::ROOT_W];

  for (genvar j = 0; j < rsi_pkg::ROOT_W; j++) begin : g_sqrt
    localparam int B = rsi_pkg::ROOT_W - 1 - j;
    rsi_pkg::sq_t                cur;
    logic [rsi_pkg::RSQ_W:0]     trial;
    logic                        take;

    if (j == 0) begin : g_head
      assign cur = s6_q;
    end else begin : g_body
      assign cur = sq_stage_q[j-1];
    end

    // (root + 2^B)^2 - root^2, with the low bits of root still zero.
    assign trial = ((rsi_pkg::RSQ_W + 1)'(cur.root) << (B + 1))
                 | ((rsi_pkg::RSQ_W + 1)'(1) << (2 * B));
    assign take  = {1'b0, cur.rem} >= trial;

    always_ff @(posedge clk_i) begin
      if (adv[rsi_pkg::SQ_FIRST + j]) begin
        sq_stage_q[j].miss <= cur.miss;
        sq_stage_q[j].tcq  <= cur.tcq;
        sq_stage_q[j].rem  <= take ? (cur.rem - trial[rsi_pkg::RSQ_W-1:0]) : cur.rem;
        sq_stage_q[j].root <= take ? (cur.root | (rsi_pkg::ROOT_W'(1) << B)) : cur.root;
      end
    end
  end

  // Output stage: entry distance with saturation.
  rsi_pkg::sq_t                      fin;
  logic signed [rsi_pkg::DIST_W-1:0] dist_raw;
  logic signed [rsi_pkg::DIST_W-1:0] dist_max;
  logic signed [rsi_pkg::DIST_W-1:0] dist_min;
  logic signed [rsi_pkg::COORD_W-1:0] dist_sat;
  logic                              hit_q;
  logic signed [rsi_pkg::COORD_W-1:0] dist_q;

  assign fin      = sq_stage_q[rsi_pkg::ROOT_W-1];
  assign dist_raw = $signed(rsi_pkg::DIST_W'(fin.tcq)) - $signed(rsi_pkg::DIST_W'(fin.root));
  assign dist_max = $signed((rsi_pkg::DIST_W'(1) << (rsi_pkg::COORD_W - 1)) - 1'b1);
  assign dist_min = -$signed(rsi_pkg::DIST_W'(1) << (rsi_pkg::COORD_W - 1));

  always_comb begin
    if (dist_raw > dist_max) begin
      dist_sat = dist_max[rsi_pkg::COORD_W-1:0];
    end else if (dist_raw < dist_min) begin
      dist_sat = dist_min[rsi_pkg::COORD_W-1:0];
    end else begin
      dist_sat = dist_raw[rsi_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      hit_q  <= !fin.miss;
      dist_q <= fin.miss ? '0 : dist_sat;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign hit_o       = hit_q;
  assign distance_o  = dist_q;

endmodule
`default_nettype wire

### tb/ray_sphere_intersection_core_test.sv
// Self-checking testbench for the pipelined ray-sphere intersection core.
`timescale 1ns / 1ps
module ray_sphere_intersection_core_test;

  // One ray-sphere query word.
  typedef struct {
    logic signed [rsi_pkg::COORD_W-1:0] cx, cy, cz;
    logic [rsi_pkg::RAD_W-1:0] rad;
    logic signed [rsi_pkg::COORD_W-1:0] ox, oy, oz;
    logic signed [rsi_pkg::DIR_W-1:0] dx, dy, dz;
  } query_t;

  // One expected answer word.
  typedef struct {
    logic hit;
    logic signed [rsi_pkg::COORD_W-1:0] entry_dist;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, hit_o;
  logic signed [rsi_pkg::COORD_W-1:0] distance_o;
  logic signed [rsi_pkg::COORD_W-1:0] cx_r = '0, cy_r = '0, cz_r = '0;
  logic signed [rsi_pkg::COORD_W-1:0] ox_r = '0, oy_r = '0, oz_r = '0;
  logic [rsi_pkg::RAD_W-1:0] rad_r = '0;
  logic signed [rsi_pkg::DIR_W-1:0] dx_r = '0, dy_r = '0, dz_r = '0;

  query_t pending_queries[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 14;
  bit sender_pause = 1'b0;
  bit stimulus_done = 1'b0;
  int hold_off = 0;

  always #2 clk_i = ~clk_i;

  ray_sphere_intersection_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .centre_x_i(cx_r), .centre_y_i(cy_r), .centre_z_i(cz_r),
    .sphere_radius_i(rad_r),
    .origin_x_i(ox_r), .origin_y_i(oy_r), .origin_z_i(oz_r),
    .dir_x_i(dx_r), .dir_y_i(dy_r), .dir_z_i(dz_r),
    .out_valid_o, .out_ready_i, .hit_o, .distance_o
  );

  // Integer square root, rounded down, of a 128-bit value.
  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Geometric intersection test with the core's exact fixed-point steps.
  function automatic answer_t intersect_ray(input query_t q);
    answer_t a;
    logic signed [127:0] l[3];
    logic signed [127:0] d[3];
    logic signed [127:0] tc, lsq, tcq, tcsq, d2, rsq, rem, entry;
    logic signed [127:0] lim;
    l[0] = 128'(q.cx) - 128'(q.ox);
    l[1] = 128'(q.cy) - 128'(q.oy);
    l[2] = 128'(q.cz) - 128'(q.oz);
    d[0] = 128'(q.dx);
    d[1] = 128'(q.dy);
    d[2] = 128'(q.dz);
    tc = '0;
    lsq = '0;
    for (int i = 0; i < 3; i++) begin
      tc += l[i] * d[i];
      lsq += l[i] * l[i];
    end
    a.hit = 1'b0;
    a.entry_dist = '0;
    if (tc < 0) return a;
    // Round half up to the coordinate fraction.
    tcq = (tc + (128'sd1 <<< (rsi_pkg::DIR_FRAC - 1))) >>> rsi_pkg::DIR_FRAC;
    tcsq = tcq * tcq;
    d2 = (tcsq < lsq) ? lsq - tcsq : tcsq - lsq;
    rsq = 128'($unsigned(q.rad)) * 128'($unsigned(q.rad));
    if (rsq < d2) return a;
    rem = rsq - d2;
    entry = tcq - 128'(isqrt128(rem));
    lim = 128'sd1 <<< (rsi_pkg::COORD_W - 1);
    if (entry > lim - 1) entry = lim - 1;
    if (entry < -lim) entry = -lim;
    a.hit = 1'b1;
    a.entry_dist = entry[rsi_pkg::COORD_W-1:0];
    return a;
  endfunction

  function automatic logic signed [rsi_pkg::COORD_W-1:0] rand_coord(input int span);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? {1'b1, {(rsi_pkg::COORD_W-1){1'b0}}}
                                     : {1'b0, {(rsi_pkg::COORD_W-1){1'b1}}};
      1, 2: return $urandom();
      default: return rsi_pkg::COORD_W'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic signed [rsi_pkg::DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return rsi_pkg::DIR_W'(16384);
      1: return -rsi_pkg::DIR_W'(16384);
      2: return $urandom();
      default: return rsi_pkg::DIR_W'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly rays aimed near a sphere, so that hits, misses and inside cases all occur.
  function automatic query_t random_query();
    query_t q;
    int span;
    span = $urandom_range(0, 3) == 0 ? 32'h4000_0000 : 32'h0080_0000;
    q.cx = rand_coord(span);
    q.cy = rand_coord(span);
    q.cz = rand_coord(span);
    q.ox = $urandom_range(0, 3) == 0 ? rand_coord(span) : q.cx + rand_coord(span / 4);
    q.oy = $urandom_range(0, 3) == 0 ? rand_coord(span) : q.cy + rand_coord(span / 4);
    q.oz = $urandom_range(0, 3) == 0 ? rand_coord(span) : q.cz + rand_coord(span / 4);
    q.rad = $urandom_range(0, 5) == 0 ? rsi_pkg::RAD_W'($urandom())
                                      : rsi_pkg::RAD_W'($urandom_range(0, span));
    q.dx = rand_dir();
    q.dy = rand_dir();
    q.dz = rand_dir();
    return q;
  endfunction

  function automatic query_t make_query(input int cx, cy, cz, rad, ox, oy, oz,
                                        input int dx, dy, dz);
    query_t q;
    q.cx = cx; q.cy = cy; q.cz = cz; q.rad = rad[rsi_pkg::RAD_W-1:0];
    q.ox = ox; q.oy = oy; q.oz = oz;
    q.dx = dx[rsi_pkg::DIR_W-1:0];
    q.dy = dy[rsi_pkg::DIR_W-1:0];
    q.dz = dz[rsi_pkg::DIR_W-1:0];
    return q;
  endfunction

  // Driver: offers queued words, idling at random. The word on the bus stays at the
  // head of the queue until it is accepted.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_answers.push_back(intersect_ray(pending_queries.pop_front()));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_queries.size() > 0 &&
            !sender_pause && $urandom_range(0, 99) >= idle_pct) begin
          query_t q;
          q = pending_queries[0];
          in_valid_i <= 1'b1;
          cx_r <= q.cx; cy_r <= q.cy; cz_r <= q.cz; rad_r <= q.rad;
          ox_r <= q.ox; oy_r <= q.oy; oz_r <= q.oz;
          dx_r <= q.dx; dy_r <= q.dy; dz_r <= q.dz;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: hit %0b dist %0d",
                                         hit_o, distance_o);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (hit_o !== e.hit || distance_o !== e.entry_dist) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit %0b dist %0d, got hit %0b dist %0d",
                       e.hit, e.entry_dist, hit_o, distance_o);
          end
        end
      end
      // Receiver side: long hold-off when requested, else random stalls.
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(0, 99) >= idle_pct;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("ray_sphere_intersection_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    int lat;
    // Directed words: field extremes, tc zero, tangent, inside, saturation.
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(0, 0, 32'h000A_0000, 32'h0002_0000,
                                         0, 0, 0, 0, 0, 16384));
    pending_queries.push_back(make_query(0, 0, 32'h000A_0000, 32'h0002_0000,
                                         0, 0, 0, 0, 0, -16384));
    pending_queries.push_back(make_query(32'h0002_0000, 0, 0, 32'h0002_0000,
                                         0, 0, 0, 0, 16384, 0));
    pending_queries.push_back(make_query(32'h0003_0000, 0, 0, 32'h0002_0000,
                                         0, 0, 0, 0, 16384, 0));
    pending_queries.push_back(make_query(0, 32'h0002_0000, 32'h000A_0000,
                                         32'h0002_0000, 0, 0, 0, 0, 0, 16384));
    pending_queries.push_back(make_query(0, 0, 0, 32'h0005_0000, 0, 0, 32'h0001_0000,
                                         0, 0, 16384));
    pending_queries.push_back(make_query(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 16384, 0, 0));
    pending_queries.push_back(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 16384, 16384, 16384));
    pending_queries.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, -16384, -16384, -16384));
    pending_queries.push_back(make_query(-1, -1, -1, 32'h5555_5555, 1, 1, 1,
                                         -1, -1, -1));
    pending_queries.push_back(make_query(32'h1234_5678, -32'h1234_5678, 0, 32'h2AAA_AAAA,
                                         0, 0, 0, 32'h7FFF, 32'h8000, 32'h5555));
    pending_queries.push_back(make_query(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0,
                                         11585, 11585, 0));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 400; i++) pending_queries.push_back(random_query());
    // Long receiver hold-off while the sender keeps offering words.
    @(posedge clk_i);
    hold_off = 120;
    wait (pending_queries.size() == 0);
    // Sender pause until every expected answer has arrived.
    sender_pause = 1'b1;
    wait (expected_answers.size() == 0);
    sender_pause = 1'b0;
    // Stretch with no idling on either side.
    idle_pct = 0;
    for (int i = 0; i < 450; i++) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0);
    idle_pct = 14;
    for (int i = 0; i < 590; i++) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0 && !in_valid_i);
    wait (expected_answers.size() == 0);
    lat = 0;
    while (lat < rsi_pkg::NSTAGE + 20) begin
      @(posedge clk_i);
      lat++;
    end
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("ray_sphere_intersection_core_test: PASS");
    end else begin
      $display("ray_sphere_intersection_core_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rsi_pkg.sv
rtl/ray_sphere_intersection_core.sv
tb/ray_sphere_intersection_core_test.sv
